// ===== src/sorted_key_table_macros.svh =====
// ----------------------------------------------------------------------------
// Sorted key table assertion macros
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_MACROS_SVH
`define SORTED_KEY_TABLE_MACROS_SVH

// Same-cycle implication, with disable on reset.
`define SKT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, with disable on reset.
`define SKT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/skt_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted key table package
// Field widths, operation and status codes, transaction types and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

   localparam int DEPTH_DEFAULT    = 16;
   localparam int KEY_BITS_DEFAULT = 64;

   localparam int OP_W      = 3;
   localparam int KEY_W     = 64;
   localparam int PAYLOAD_W = 32;
   localparam int POS_W     = 4;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 5;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 3'd0,
      OP_UPDATE = 3'd1,
      OP_DELETE = 3'd2,
      OP_FIND   = 3'd3,
      OP_GET    = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_BADPOS   = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef struct packed {
      op_type               op;
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
      logic [POS_W-1:0]     position;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [POS_W-1:0]     found_position;
      logic [KEY_W-1:0]     key_out;
      logic [PAYLOAD_W-1:0] payload_out;
      logic [COUNT_W-1:0]   entry_count;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_INS_SHIFT,
      S_INS_PLACE,
      S_DEL_SHIFT,
      S_FIND_LAST,
      S_FIND_SCAN,
      S_GET_READ
   } state_type;

   typedef enum logic [2:0] {
      C_HOLD,
      C_LOAD_COUNT,
      C_LOAD_POS,
      C_ZERO,
      C_DEC,
      C_INC
   } c_op_type;

   typedef enum logic [2:0] {
      RD_NONE,
      RD_LAST,
      RD_BELOW,
      RD_ABOVE,
      RD_AT
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_SHIFT,
      WR_NEW_AT_C,
      WR_NEW_AT_POS
   } wr_sel_type;

   typedef enum logic [1:0] {
      POS_ZERO,
      POS_C,
      POS_REQ
   } pos_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   typedef struct packed {
      logic        capture;
      c_op_type    c_op;
      rd_sel_type  rd_sel;
      wr_sel_type  wr_sel;
      cnt_op_type  cnt_op;
      logic        rsp_load;
      status_type  rsp_status;
      pos_sel_type rsp_pos_sel;
      logic        rsp_key_en;
      logic        rsp_pay_en;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   count_zero;
      logic   full;
      logic   pos_bad;
      logic   pos_last;
      logic   key_lt;
      logic   key_gt;
      logic   key_eq;
      logic   c_one;
      logic   del_more;
      logic   scan_more;
   } stat_type;

endpackage

`default_nettype wire

// ===== src/sorted_key_table.sv =====
// ----------------------------------------------------------------------------
// Sorted key table
// Up to DEPTH key/payload entries kept in ascending key order, with insert,
// update, delete, find and get operations.
//
//   channel   ports                          direction  handshake
//   request   start, busy, req_item          in         start && !busy
//   response  rsp_strobe, rsp_item           out        rsp_strobe, one cycle
//
// One transaction at a time; busy stays high until its response is loaded.
// Update, last-entry delete, unused ops, full, bad position and empty find:
// reply from dispatch; get: read the entry, then reply. Insert moves each
// larger entry up one slot, then places the new one; other deletes close up
// the entries above the position. Find reads the last entry and replies for a
// key above it, else scans up from slot 0. The walk moves one entry per cycle
// through the single read and single write port of the entry memory.
// Reset clears the entry count and control only; the memory is not cleared.
// The response cannot be held off; a new start is taken in the strobe cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table
   import skt_pkg::*;
#(
   parameter int DEPTH    = DEPTH_DEFAULT,
   parameter int KEY_BITS = KEY_BITS_DEFAULT
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_strobe,
   output rsp_type      rsp_item
);

   cmd_type  cmd;
   stat_type stat;

   skt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   skt_datapath #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_item   (rsp_item),
      .rsp_strobe (rsp_strobe)
   );

endmodule

`default_nettype wire

// ===== src/skt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sorted key table controller
// Sequences each operation: dispatch, table walk and reply.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_ctrl
   import skt_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   output logic          busy,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            state_in = S_IDLE;
            unique case (stat.op)
               OP_INSERT: begin
                  if (!stat.full) state_in = stat.count_zero ? S_INS_PLACE : S_INS_SHIFT;
               end
               OP_DELETE: begin
                  if (!stat.pos_bad && !stat.pos_last) state_in = S_DEL_SHIFT;
               end
               OP_FIND: begin
                  if (!stat.count_zero) state_in = S_FIND_LAST;
               end
               OP_GET: begin
                  if (!stat.pos_bad) state_in = S_GET_READ;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_INS_SHIFT: begin
            if (!stat.key_lt) state_in = S_IDLE;
            else if (stat.c_one) state_in = S_INS_PLACE;
         end
         S_INS_PLACE: state_in = S_IDLE;
         S_DEL_SHIFT: begin
            if (!stat.del_more) state_in = S_IDLE;
         end
         S_FIND_LAST: state_in = stat.key_gt ? S_IDLE : S_FIND_SCAN;
         S_FIND_SCAN: begin
            if (!(stat.key_gt && stat.scan_more)) state_in = S_IDLE;
         end
         S_GET_READ: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.c_op        = C_HOLD;
      cmd.rd_sel      = RD_NONE;
      cmd.wr_sel      = WR_NONE;
      cmd.cnt_op      = CNT_HOLD;
      cmd.rsp_status  = ST_OK;
      cmd.rsp_pos_sel = POS_ZERO;
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = start;
         end
         S_DISPATCH: begin
            unique case (stat.op)
               OP_INSERT: begin
                  if (stat.full) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = ST_FULL;
                  end else begin
                     cmd.c_op = C_LOAD_COUNT;
                     if (!stat.count_zero) cmd.rd_sel = RD_BELOW;
                  end
               end
               OP_UPDATE: begin
                  cmd.rsp_load = 1'b1;
                  if (stat.pos_bad) begin
                     cmd.rsp_status = ST_BADPOS;
                  end else begin
                     cmd.wr_sel      = WR_NEW_AT_POS;
                     cmd.rsp_pos_sel = POS_REQ;
                  end
               end
               OP_DELETE: begin
                  if (stat.pos_bad) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = ST_BADPOS;
                  end else if (stat.pos_last) begin
                     // last entry: nothing to close up
                     cmd.cnt_op      = CNT_DEC;
                     cmd.rsp_load    = 1'b1;
                     cmd.rsp_pos_sel = POS_REQ;
                  end else begin
                     cmd.c_op   = C_LOAD_POS;
                     cmd.rd_sel = RD_ABOVE;
                  end
               end
               OP_FIND: begin
                  if (stat.count_zero) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = ST_NOTFOUND;
                  end else begin
                     cmd.rd_sel = RD_LAST;
                  end
               end
               OP_GET: begin
                  if (stat.pos_bad) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = ST_BADPOS;
                  end else begin
                     cmd.c_op   = C_LOAD_POS;
                     cmd.rd_sel = RD_AT;
                  end
               end
               default: begin
                  cmd.rsp_load = 1'b1;
               end
            endcase
         end
         S_INS_SHIFT: begin
            if (stat.key_lt) begin
               // move the larger entry up one slot
               cmd.wr_sel = WR_SHIFT;
               cmd.c_op   = C_DEC;
               if (!stat.c_one) cmd.rd_sel = RD_BELOW;
            end else begin
               cmd.wr_sel      = WR_NEW_AT_C;
               cmd.cnt_op      = CNT_INC;
               cmd.rsp_load    = 1'b1;
               cmd.rsp_pos_sel = POS_C;
            end
         end
         S_INS_PLACE: begin
            cmd.wr_sel      = WR_NEW_AT_C;
            cmd.cnt_op      = CNT_INC;
            cmd.rsp_load    = 1'b1;
            cmd.rsp_pos_sel = POS_C;
         end
         S_DEL_SHIFT: begin
            cmd.wr_sel = WR_SHIFT;
            if (stat.del_more) begin
               cmd.c_op   = C_INC;
               cmd.rd_sel = RD_ABOVE;
            end else begin
               cmd.cnt_op      = CNT_DEC;
               cmd.rsp_load    = 1'b1;
               cmd.rsp_pos_sel = POS_REQ;
            end
         end
         S_FIND_LAST: begin
            if (stat.key_gt) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = ST_NOTFOUND;
            end else begin
               cmd.c_op   = C_ZERO;
               cmd.rd_sel = RD_AT;
            end
         end
         S_FIND_SCAN: begin
            if (stat.key_gt && stat.scan_more) begin
               cmd.c_op   = C_INC;
               cmd.rd_sel = RD_AT;
            end else if (stat.key_eq) begin
               cmd.rsp_load    = 1'b1;
               cmd.rsp_pos_sel = POS_C;
               cmd.rsp_pay_en  = 1'b1;
            end else begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = ST_NOTFOUND;
            end
         end
         S_GET_READ: begin
            cmd.rsp_load    = 1'b1;
            cmd.rsp_pos_sel = POS_C;
            cmd.rsp_key_en  = 1'b1;
            cmd.rsp_pay_en  = 1'b1;
         end
         default: begin
            cmd.capture = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== src/skt_datapath.sv =====
// ----------------------------------------------------------------------------
// Sorted key table datapath
// Request register, entry memory, walk index, entry count and reply register.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_datapath
   import skt_pkg::*;
#(
   parameter int DEPTH    = DEPTH_DEFAULT,
   parameter int KEY_BITS = KEY_BITS_DEFAULT
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_item,
   input  wire cmd_type cmd,
   output stat_type     stat,
   output rsp_type      rsp_item,
   output logic         rsp_strobe
);

   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam int ENTRY_W = KEY_BITS + PAYLOAD_W;

   op_type               op_ff;
   logic [KEY_BITS-1:0]  key_ff;
   logic [PAYLOAD_W-1:0] pay_ff;
   logic [POS_W-1:0]     pos_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic [IDX_W-1:0]     c_ff;
   logic [IDX_W-1:0]     c_in;
   logic [ENTRY_W-1:0]   rd_ff;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;
   logic                 strobe_ff;

   logic [ENTRY_W-1:0]   mem [DEPTH];

   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [ENTRY_W-1:0]   wr_data;
   logic [KEY_BITS-1:0]  rd_key;
   logic [PAYLOAD_W-1:0] rd_pay;
   logic [CMP_W-1:0]     pos_x;
   logic [CMP_W-1:0]     cnt_x;
   logic [CMP_W-1:0]     c_x;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_item.op;
         key_ff <= req_item.key[KEY_BITS-1:0];
         pay_ff <= req_item.payload;
         pos_ff <= req_item.position;
      end
   end

   assign rd_key = rd_ff[ENTRY_W-1 -: KEY_BITS];
   assign rd_pay = rd_ff[PAYLOAD_W-1:0];
   assign pos_x  = CMP_W'(pos_ff);
   assign cnt_x  = CMP_W'(count_ff);
   assign c_x    = CMP_W'(c_ff);

   always_comb begin
      stat.op         = op_ff;
      stat.count_zero = (count_ff == '0);
      stat.full       = (count_ff == CNT_W'(DEPTH));
      stat.pos_bad    = (pos_x >= cnt_x);
      stat.pos_last   = ((pos_x + CMP_W'(1)) == cnt_x);
      stat.key_lt     = (key_ff < rd_key);
      stat.key_gt     = (key_ff > rd_key);
      stat.key_eq     = (key_ff == rd_key);
      stat.c_one      = (c_ff == IDX_W'(1));
      stat.del_more   = ((c_x + CMP_W'(2)) < cnt_x);
      stat.scan_more  = ((c_x + CMP_W'(1)) < cnt_x);
   end

   // walk index
   always_comb begin
      unique case (cmd.c_op)
         C_HOLD:       c_in = c_ff;
         C_LOAD_COUNT: c_in = IDX_W'(count_ff);
         C_LOAD_POS:   c_in = IDX_W'(pos_ff);
         C_ZERO:       c_in = '0;
         C_DEC:        c_in = c_ff - IDX_W'(1);
         C_INC:        c_in = c_ff + IDX_W'(1);
         default:      c_in = c_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      c_ff <= c_in;
   end

   // memory ports
   always_comb begin
      rd_en = (cmd.rd_sel != RD_NONE);
      unique case (cmd.rd_sel)
         RD_LAST:  rd_addr = IDX_W'(count_ff - CNT_W'(1));
         RD_BELOW: rd_addr = c_in - IDX_W'(1);
         RD_ABOVE: rd_addr = c_in + IDX_W'(1);
         RD_AT:    rd_addr = c_in;
         default:  rd_addr = c_in;
      endcase
   end

   always_comb begin
      wr_en = (cmd.wr_sel != WR_NONE);
      unique case (cmd.wr_sel)
         WR_SHIFT: begin
            wr_addr = c_ff;
            wr_data = rd_ff;
         end
         WR_NEW_AT_C: begin
            wr_addr = c_ff;
            wr_data = {key_ff, pay_ff};
         end
         WR_NEW_AT_POS: begin
            wr_addr = IDX_W'(pos_ff);
            wr_data = {key_ff, pay_ff};
         end
         default: begin
            wr_addr = c_ff;
            wr_data = rd_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   // entry count
   always_comb begin
      unique case (cmd.cnt_op)
         CNT_INC: count_in = count_ff + CNT_W'(1);
         CNT_DEC: count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // reply register
   always_comb begin
      rsp_in.status = cmd.rsp_status;
      unique case (cmd.rsp_pos_sel)
         POS_C:   rsp_in.found_position = POS_W'(c_ff);
         POS_REQ: rsp_in.found_position = pos_ff;
         default: rsp_in.found_position = '0;
      endcase
      rsp_in.key_out     = cmd.rsp_key_en ? KEY_W'(rd_key) : '0;
      rsp_in.payload_out = cmd.rsp_pay_en ? rd_pay : '0;
      rsp_in.entry_count = COUNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.rsp_load;
      end
   end

   assign rsp_item   = rsp_ff;
   assign rsp_strobe = strobe_ff;

endmodule

`default_nettype wire

// ===== src/skt_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted key table port checker
// Watches the top-level ports for transaction sequencing and reply contents.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_key_table_macros.svh"

module skt_checker
   import skt_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_strobe,
   input wire rsp_type rsp_item
);

   `SKT_ASSERT_NEXT(a_accept_goes_busy, clock, reset, start && !busy, busy,
      "accept without busy")
   `SKT_ASSERT_SAME(a_strobe_when_idle, clock, reset, rsp_strobe, !busy,
      "response while busy")
   `SKT_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe,
      "back to back responses")
   `SKT_ASSERT_SAME(a_error_zero_data, clock, reset,
      rsp_strobe && rsp_item.status != ST_OK,
      rsp_item.found_position == '0 && rsp_item.key_out == '0 &&
      rsp_item.payload_out == '0,
      "error reply carries data")
   `SKT_ASSERT_SAME(a_reset_quiet, clock, 1'b0, $past(reset), !rsp_strobe && !busy,
      "activity right after reset")

endmodule

bind sorted_key_table skt_checker u_skt_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

`default_nettype wire
